// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define PWS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, held off during reset
`define PWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== src/pws_pkg.sv =====
// shared constants and types for the world-to-screen projection core
// no dependencies
package pws_pkg;

  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int DIM_BITS   = 14;
  localparam int COEF_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_FRAC  = 24;
  localparam int HALF_SHIFT = 15;
  localparam int HALF_Q     = 32768;
  localparam int W_MIN      = 656;

  localparam logic [DIM_BITS-1:0] WIDTH_RST  = 14'd2560;
  localparam logic [DIM_BITS-1:0] HEIGHT_RST = 14'd1440;

  typedef enum logic [2:0] {
    REG_ROW0_XY = 3'd0,
    REG_ROW0_ZC = 3'd1,
    REG_ROW1_XY = 3'd2,
    REG_ROW1_ZC = 3'd3,
    REG_ROW3_XY = 3'd4,
    REG_ROW3_ZC = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } pws_sb_t;

endpackage

// ===== src/pws_if.sv =====
// valid/ready channel interfaces for world points and screen results
// no dependencies
interface pws_pt_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] world_x;
  logic signed [COORD_BITS-1:0] world_y;
  logic signed [COORD_BITS-1:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface pws_px_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;

  modport source (output valid, visible, pixel_x, pixel_y, input ready);
  modport sink   (input valid, visible, pixel_x, pixel_y, output ready);
endinterface

// ===== src/pws_dot.sv =====
// four-stage dot product of one matrix row with a world point
// depends on pws_pkg
module pws_dot #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [COORD_BITS-1:0]        x_i,
  input  logic signed [COORD_BITS-1:0]        y_i,
  input  logic signed [COORD_BITS-1:0]        z_i,
  input  logic [pws_pkg::DATA_W-1:0]          coef_xy_i,
  input  logic [pws_pkg::DATA_W-1:0]          coef_zc_i,
  output logic signed [((COORD_BITS > 25) ? COORD_BITS : 25)+10:0] dot_o
);
  import pws_pkg::*;

  localparam int XW  = (COORD_BITS > 25) ? COORD_BITS : 25;
  localparam int HW  = XW - COEF_FRAC;
  localparam int PHW = HW + COEF_W;
  localparam int PLW = COEF_FRAC + 1 + COEF_W;
  localparam int TW  = XW + 9;
  localparam int DW  = XW + 11;

  logic signed [XW-1:0]     crd [3];
  logic signed [COEF_W-1:0] k   [3];
  logic signed [COEF_W-1:0] off;

  logic signed [PHW-1:0] ph_q [3];
  logic signed [PLW-1:0] pl_q [3];
  logic signed [TW-1:0]  t_q  [3];
  logic signed [DW-1:0]  s01_q, s2o_q, dot_q;

  assign crd[0] = XW'(x_i);
  assign crd[1] = XW'(y_i);
  assign crd[2] = XW'(z_i);
  assign k[0]   = $signed(coef_xy_i[COEF_W-1:0]);
  assign k[1]   = $signed(coef_xy_i[DATA_W-1:COEF_W]);
  assign k[2]   = $signed(coef_zc_i[COEF_W-1:0]);
  assign off    = $signed(coef_zc_i[DATA_W-1:COEF_W]);

  // coordinate split into a signed high part and an unsigned 24-bit low part
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        ph_q[j] <= $signed(crd[j][XW-1:COEF_FRAC]) * k[j];
        pl_q[j] <= $signed({1'b0, crd[j][COEF_FRAC-1:0]}) * k[j];
      end
    end
  end

  // floor of the low partial product lands in the Q25.16 term at the default width
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        t_q[j] <= TW'(ph_q[j]) + TW'(pl_q[j] >>> COEF_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s01_q <= DW'(t_q[0]) + DW'(t_q[1]);
      s2o_q <= DW'(t_q[2]) + DW'(off);
      dot_q <= s01_q + s2o_q;
    end
  end

  assign dot_o = dot_q;

endmodule

// ===== src/pws_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on pws_pkg
module pws_div #(
  parameter int DW = 43,
  parameter int QB = 33
) (
  input  logic                                           clk_i,
  input  logic                                           en_i,
  input  logic [DW+pws_pkg::DIM_BITS+pws_pkg::HALF_SHIFT-1:0] num_i,
  input  logic [DW-1:0]                                  den_i,
  output logic [QB-1:0]                                  q_o,
  output logic                                           sat_o
);
  import pws_pkg::*;

  localparam int NW = DW + DIM_BITS + HALF_SHIFT;

  logic [DW-1:0] rem_q [0:QB-1];
  logic [QB-1:0] low_q [0:QB-1];
  logic [DW-1:0] den_q [0:QB-1];
  logic [QB-1:0] quo_q [0:QB];
  logic          sat_q [0:QB];
  logic [DW-1:0] rem0;

  // upper dividend bits at or above the divisor mean the quotient overflows
  assign rem0 = DW'(num_i[NW-1:QB]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      sat_q[0] <= (rem0 >= den_i);
      low_q[0] <= num_i[QB-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW-1:0] trial;
    logic          ge;

    assign trial = {rem_q[s-1][DW-2:0], low_q[s-1][QB-1]};
    assign ge    = (trial >= den_q[s-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {quo_q[s-1][QB-2:0], ge};
        sat_q[s] <= sat_q[s-1];
      end
    end

    if (s < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? (trial - den_q[s-1]) : trial;
          low_q[s] <= low_q[s-1] << 1;
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign q_o   = quo_q[QB];
  assign sat_o = sat_q[QB];

endmodule

// ===== src/perspective_world_to_screen_core.sv =====
// throughput: one point per cycle while no result is held; the divider makes one quotient bit per stage
// output register stalls the whole pipeline only while a result waits untaken
// reset: valid bits cleared, matrix registers zero, viewport 2560 x 1440
// depends on pws_pkg, pws_if, pws_dot and pws_div
module perspective_world_to_screen_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pws_pt_if.sink                       pt_i,
  pws_px_if.source                     px_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pws_pkg::ADDR_W-1:0]   paddr,
  input  logic [pws_pkg::DATA_W-1:0]   pwdata,
  output logic [pws_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pws_pkg::*;

  localparam int XW  = (COORD_BITS > 25) ? COORD_BITS : 25;
  localparam int DW  = XW + 11;
  localparam int QB  = ((COORD_BITS > 30) ? COORD_BITS : 30) + 1;
  localparam int NW  = DW + DIM_BITS + HALF_SHIFT;
  localparam int PW  = DW + DIM_BITS;
  localparam int SW  = QB + 2;
  localparam int NST = QB + 8;

  localparam logic signed [SW-1:0] MAXV =
    {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;
  localparam logic signed [DW-1:0] WMIN_S = DW'(W_MIN);
  localparam logic signed [SW-1:0] HALF_S = SW'(HALF_Q);

  // configuration registers
  logic [DATA_W-1:0]   row0_xy_q, row0_zc_q, row1_xy_q, row1_zc_q, row3_xy_q, row3_zc_q;
  logic [DIM_BITS-1:0] width_q, height_q;
  logic                wr_en;
  cfg_reg_e            reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_xy_q <= '0;
      row0_zc_q <= '0;
      row1_xy_q <= '0;
      row1_zc_q <= '0;
      row3_xy_q <= '0;
      row3_zc_q <= '0;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ROW0_XY: row0_xy_q <= pwdata;
        REG_ROW0_ZC: row0_zc_q <= pwdata;
        REG_ROW1_XY: row1_xy_q <= pwdata;
        REG_ROW1_ZC: row1_zc_q <= pwdata;
        REG_ROW3_XY: row3_xy_q <= pwdata;
        REG_ROW3_ZC: row3_zc_q <= pwdata;
        REG_WIDTH:   width_q   <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT:  height_q  <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW0_XY: prdata = row0_xy_q;
      REG_ROW0_ZC: prdata = row0_zc_q;
      REG_ROW1_XY: prdata = row1_xy_q;
      REG_ROW1_ZC: prdata = row1_zc_q;
      REG_ROW3_XY: prdata = row3_xy_q;
      REG_ROW3_ZC: prdata = row3_zc_q;
      REG_WIDTH:   prdata = DATA_W'(width_q);
      REG_HEIGHT:  prdata = DATA_W'(height_q);
      default:     prdata = '0;
    endcase
  end

  // pipeline control: every stage moves together unless the result is held
  logic            en;
  logic            vld_q [1:NST];
  pws_sb_t         sb_q  [5:NST-1];

  assign en       = !vld_q[NST] || px_o.ready;
  assign pt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NST; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= pt_i.valid;
      for (int s = 2; s <= NST; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // stages 1 to 4: row dot products
  logic signed [DW-1:0] cx, cy, cw;

  pws_dot #(.COORD_BITS(COORD_BITS)) u_dot_x (
    .clk_i(clk_i), .en_i(en), .x_i(pt_i.world_x), .y_i(pt_i.world_y), .z_i(pt_i.world_z),
    .coef_xy_i(row0_xy_q), .coef_zc_i(row0_zc_q), .dot_o(cx)
  );

  pws_dot #(.COORD_BITS(COORD_BITS)) u_dot_y (
    .clk_i(clk_i), .en_i(en), .x_i(pt_i.world_x), .y_i(pt_i.world_y), .z_i(pt_i.world_z),
    .coef_xy_i(row1_xy_q), .coef_zc_i(row1_zc_q), .dot_o(cy)
  );

  pws_dot #(.COORD_BITS(COORD_BITS)) u_dot_w (
    .clk_i(clk_i), .en_i(en), .x_i(pt_i.world_x), .y_i(pt_i.world_y), .z_i(pt_i.world_z),
    .coef_xy_i(row3_xy_q), .coef_zc_i(row3_zc_q), .dot_o(cw)
  );

  // stage 5: magnitudes, visibility and divisor
  logic [DW-1:0] magx_q, magy_q, den5_q, den6_q;
  logic [NW-1:0] numx_q, numy_q;
  logic [PW-1:0] prodx, prody;

  always_ff @(posedge clk_i) begin
    if (en) begin
      magx_q    <= cx[DW-1] ? DW'(-cx) : DW'(cx);
      magy_q    <= cy[DW-1] ? DW'(-cy) : DW'(cy);
      den5_q    <= {1'b0, cw[DW-2:0]};
      sb_q[5]   <= '{vis: (cw >= WMIN_S), neg_x: cx[DW-1], neg_y: cy[DW-1]};
    end
  end

  // stage 6: scale by the viewport size, the half factor is a shift
  assign prodx = PW'(magx_q) * PW'(width_q);
  assign prody = PW'(magy_q) * PW'(height_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q <= {prodx, {HALF_SHIFT{1'b0}}};
      numy_q <= {prody, {HALF_SHIFT{1'b0}}};
      den6_q <= den5_q;
      for (int s = 6; s <= NST-1; s++) sb_q[s] <= sb_q[s-1];
    end
  end

  // stages 7 to NST-1: division
  logic [QB-1:0] qx, qy;
  logic          satx, saty;

  pws_div #(.DW(DW), .QB(QB)) u_div_x (
    .clk_i(clk_i), .en_i(en), .num_i(numx_q), .den_i(den6_q), .q_o(qx), .sat_o(satx)
  );

  pws_div #(.DW(DW), .QB(QB)) u_div_y (
    .clk_i(clk_i), .en_i(en), .num_i(numy_q), .den_i(den6_q), .q_o(qy), .sat_o(saty)
  );

  // final stage: sign, screen offset and saturation
  logic signed [SW-1:0] qxs, qys, sx, sy, base_x, base_y, px_full, py_full;
  logic signed [SW-1:0] px_sat, py_sat;

  always_comb begin
    // an overflowed quotient saturates the pixel either way
    qxs     = satx ? SW'({QB{1'b1}}) : SW'(qx);
    qys     = saty ? SW'({QB{1'b1}}) : SW'(qy);
    sx      = sb_q[NST-1].neg_x ? -qxs : qxs;
    sy      = sb_q[NST-1].neg_y ? -qys : qys;
    base_x  = SW'({width_q[DIM_BITS-1:1], 1'b1, {(FRAC_BITS-1){1'b0}}});
    base_y  = SW'({height_q[DIM_BITS-1:1], {FRAC_BITS{1'b0}}});
    px_full = base_x + sx;
    py_full = base_y - sy - HALF_S;
    px_sat  = (px_full > MAXV) ? MAXV : ((px_full < MINV) ? MINV : px_full);
    py_sat  = (py_full > MAXV) ? MAXV : ((py_full < MINV) ? MINV : py_full);
  end

  logic                         vis_q;
  logic signed [COORD_BITS-1:0] pix_x_q, pix_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q   <= sb_q[NST-1].vis;
      pix_x_q <= sb_q[NST-1].vis ? COORD_BITS'(px_sat) : '0;
      pix_y_q <= sb_q[NST-1].vis ? COORD_BITS'(py_sat) : '0;
    end
  end

  assign px_o.valid   = vld_q[NST];
  assign px_o.visible = vis_q;
  assign px_o.pixel_x = pix_x_q;
  assign px_o.pixel_y = pix_y_q;

endmodule

// ===== src/pws_checker.sv =====
// port-level checks for the projection core, bound onto the top level
// depends on assert_macros.svh and perspective_world_to_screen_core
`include "assert_macros.svh"

module pws_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         visible_i,
  input logic signed [COORD_BITS-1:0] pixel_x_i,
  input logic signed [COORD_BITS-1:0] pixel_y_i
);

  // a waiting result keeps its contents until the transfer
  `PWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i) && $stable(visible_i))

  // hidden points report zero coordinates
  `PWS_ASSERT_NOW(a_hidden_zero, clk_i, rst_ni, out_valid_i && !visible_i, pixel_x_i == '0 && pixel_y_i == '0)

  // input never stalls while the output side takes results
  `PWS_ASSERT_NOW(a_ready_flow, clk_i, rst_ni, out_ready_i, in_ready_i)

  // input stalls only behind a held result
  `PWS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind perspective_world_to_screen_core pws_checker #(.COORD_BITS(COORD_BITS)) u_pws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (px_o.valid),
  .out_ready_i (px_o.ready),
  .visible_i   (px_o.visible),
  .pixel_x_i   (px_o.pixel_x),
  .pixel_y_i   (px_o.pixel_y)
);
